@@ design/mh2_pkg.sv @@
// Shared types and constants for the MurmurHash2 32-bit block.
// Used by mh2_front, mh2_queue, mh2_back and murmur2_hash32.
package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
  localparam int          WORD_SHIFT  = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  // Default number of entries in the front-to-back queue
  localparam int QUEUE_DEPTH_DEF = 4;

  // How the back end folds a word into the accumulator
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TAIL = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  // One classified word on its way from front to back
  typedef struct packed {
    logic [31:0] payload;   // mixed word (full) or masked bytes (tail)
    kind_t       kind;
    logic        first;
    logic        last;
    logic [30:0] key_length;
  } item_t;

endpackage

@@ design/mh2_front.sv @@
// Front end: accepts key words, classifies them and runs the per-word mix.
// Depends on mh2_pkg; feeds mh2_queue.
module mh2_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_data_word,
  input  logic [2:0]          in_valid_bytes,
  input  logic                in_first_item,
  input  logic                in_last_item,
  input  logic [30:0]         in_key_length,
  output logic                push_valid,
  input  logic                push_stall,
  output mh2_pkg::item_t      push_item
);
  import mh2_pkg::*;

  logic        s1_v_r, s1_v_nxt;
  item_t       s1_r;
  logic        s2_v_r, s2_v_nxt;
  item_t       s2_r;
  logic        s1_ready, s2_ready;
  logic        in_take;
  kind_t       in_kind;
  logic [31:0] in_mask;
  logic [31:0] in_prod;
  logic [31:0] s1_shx;
  logic [31:0] s1_prod;

  // Classify the incoming word by its byte count
  always_comb begin
    in_kind = KIND_FULL;
    in_mask = 32'hffff_ffff;
    case (in_valid_bytes)
      3'd0: begin
        in_kind = KIND_NONE;
        in_mask = 32'h0000_0000;
      end
      3'd1: begin
        in_kind = KIND_TAIL;
        in_mask = 32'h0000_00ff;
      end
      3'd2: begin
        in_kind = KIND_TAIL;
        in_mask = 32'h0000_ffff;
      end
      3'd3: begin
        in_kind = KIND_TAIL;
        in_mask = 32'h00ff_ffff;
      end
      default: begin
        in_kind = KIND_FULL;
        in_mask = 32'hffff_ffff;
      end
    endcase
  end

  // First multiply of the word mix
  assign in_prod = in_data_word * MIX_MUL;
  // Shift-XOR and second multiply
  assign s1_shx  = s1_r.payload ^ (s1_r.payload >> WORD_SHIFT);
  assign s1_prod = s1_shx * MIX_MUL;

  // Advance a stage when the one after it has room
  assign s2_ready   = !s2_v_r || !push_stall;
  assign s1_ready   = !s1_v_r || s2_ready;
  assign in_stall   = !s1_ready;
  assign in_take    = in_valid && s1_ready;
  assign push_valid = s2_v_r;
  assign push_item  = s2_r;

  always_comb begin
    s1_v_nxt = s1_ready ? in_valid : s1_v_r;
    s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;
  end

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Move payload down the pipe
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.payload    <= (in_kind == KIND_FULL) ? in_prod : (in_data_word & in_mask);
      s1_r.kind       <= in_kind;
      s1_r.first      <= in_first_item;
      s1_r.last       <= in_last_item;
      s1_r.key_length <= in_key_length;
    end
    if (s2_ready && s1_v_r) begin
      s2_r.payload    <= (s1_r.kind == KIND_FULL) ? s1_prod : s1_r.payload;
      s2_r.kind       <= s1_r.kind;
      s2_r.first      <= s1_r.first;
      s2_r.last       <= s1_r.last;
      s2_r.key_length <= s1_r.key_length;
    end
  end

endmodule

@@ design/mh2_queue.sv @@
// Short FIFO of classified words between front and back ends.
// Depends on mh2_pkg for the item type.
module mh2_queue #(
  parameter int DEPTH = mh2_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_stall,
  input  mh2_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_take,
  output mh2_pkg::item_t pop_item
);
  import mh2_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_stall = (count_r == CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && pop_take;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/mh2_back.sv @@
// Back end: folds words into the accumulator, finalizes and emits the hash.
// Depends on mh2_pkg; takes words from mh2_queue.
module mh2_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  input  logic           pop_valid,
  output logic           pop_take,
  input  mh2_pkg::item_t pop_item,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_hash_value
);
  import mh2_pkg::*;

  logic [31:0] seed_r;
  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [31:0] h_start;
  logic [31:0] mul_in;
  logic [31:0] mul_out;
  logic        do_pop;
  logic        f0_v_r, f1_v_r, out_v_r;
  logic        f0_v_nxt, f1_v_nxt, out_v_nxt;
  logic [31:0] f0_r, f1_r, out_r;
  logic [31:0] f0_shx, f0_prod;
  logic        out_ready, f1_ready, f0_ready;

  // Finalization pipe handshake
  assign out_ready = !out_v_r || !out_stall;
  assign f1_ready  = !f1_v_r || out_ready;
  assign f0_ready  = !f0_v_r || f1_ready;

  // Take a word unless it ends a key and the finalizer is full
  assign pop_take = !pop_item.last || f0_ready;
  assign do_pop   = pop_valid && pop_take;

  // Accumulator step: one multiply per word
  assign h_start = pop_item.first ? (seed_r ^ {1'b0, pop_item.key_length}) : acc_r;
  assign mul_in  = (pop_item.kind == KIND_TAIL) ? (h_start ^ pop_item.payload) : h_start;
  assign mul_out = mul_in * MIX_MUL;

  always_comb begin
    case (pop_item.kind)
      KIND_FULL: acc_nxt = mul_out ^ pop_item.payload;
      KIND_TAIL: acc_nxt = mul_out;
      default:   acc_nxt = h_start;
    endcase
  end

  // Finalization arithmetic
  assign f0_shx  = f0_r ^ (f0_r >> FIN_SHIFT_A);
  assign f0_prod = f0_shx * MIX_MUL;

  always_comb begin
    f0_v_nxt  = f0_ready ? (do_pop && pop_item.last) : f0_v_r;
    f1_v_nxt  = f1_ready ? f0_v_r : f1_v_r;
    out_v_nxt = out_ready ? f1_v_r : out_v_r;
  end

  // Control state, seed and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      acc_r   <= '0;
      f0_v_r  <= 1'b0;
      f1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      if (do_pop) begin
        acc_r <= acc_nxt;
      end
      f0_v_r  <= f0_v_nxt;
      f1_v_r  <= f1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Finalizer payload; hold while stalled
  always_ff @(posedge clk) begin
    if (f0_ready && do_pop && pop_item.last) begin
      f0_r <= acc_nxt;
    end
    if (f1_ready && f0_v_r) begin
      f1_r <= f0_prod;
    end
    if (out_ready && f1_v_r) begin
      out_r <= f1_r ^ (f1_r >> FIN_SHIFT_B);
    end
  end

  assign out_valid      = out_v_r;
  assign out_hash_value = out_r;

endmodule

@@ design/murmur2_hash32.sv @@
// MurmurHash2 32-bit streaming hash, top level.
// Input channel: one 32-bit little-endian key word per accepted item, with
//   in_valid_bytes (0..7, values above 4 count as a full word), in_first_item, in_last_item and in_key_length
//   (read on the first word). A zero-length key is one word with no bytes.
// Result channel: out_valid/out_stall with out_hash_value, one result for
//   each word marked last.
// Configuration: cfg_we writes cfg_wdata into the seed register; write it
//   only while no key is in flight.
// The last word of a key passes front stages s1 and s2, the queue, finalizer registers f0 and f1
//   and the output register before out_valid rises; a stall on either side holds it back.
// Throughput: one word per cycle while neither side stalls, set by the single constant multiply and
//   XOR in the accumulator loop of the back end; the two word-mix multiplies
//   run ahead in the front pipeline.
// Reset (rst_n low, synchronous): seed and accumulator clear to zero, all
//   pipeline and queue entries are dropped.
// When out_stall is high the finished hash holds on the port; the
//   finalizer, queue and front pipeline fill up behind it and in_stall rises
//   only once they are all full.
module murmur2_hash32 #(
  parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_first_item,
  input  logic        in_last_item,
  input  logic [30:0] in_key_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);
  import mh2_pkg::*;

  logic  push_valid, push_stall;
  item_t push_item;
  logic  pop_valid, pop_take;
  item_t pop_item;

  mh2_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_first_item  (in_first_item),
    .in_last_item   (in_last_item),
    .in_key_length  (in_key_length),
    .push_valid     (push_valid),
    .push_stall     (push_stall),
    .push_item      (push_item)
  );

  mh2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_item   (pop_item)
  );

  mh2_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .pop_valid      (pop_valid),
    .pop_take       (pop_take),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

@@ tb/sv/mh2_checker.sv @@
`timescale 1ns / 100ps
// Checker for murmur2_hash32: tracks seed writes and accepted key words,
// predicts each finished hash and compares it with the result channel.
// Depends on mh2_pkg for the mixing constants.
module mh2_checker
  import mh2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_first_item,
  input  logic        in_last_item,
  input  logic [30:0] in_key_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_hash_value,
  output int          n_fail,
  output int          n_pending
);

  localparam int FULL_WORD_BYTES = 4;

  logic [31:0] seed_reg;
  logic [31:0] running_hash;
  logic [31:0] hash_expect_q[$];

  // Fold one full key word: mix it, then merge into the running hash
  function automatic logic [31:0] mix_full_word(input logic [31:0] acc,
                                                input logic [31:0] w);
    logic [31:0] k;
    k = w * MIX_MUL;
    k = k ^ (k >> WORD_SHIFT);
    k = k * MIX_MUL;
    return (acc * MIX_MUL) ^ k;
  endfunction

  // Fold the 1 to 3 trailing bytes of a key
  function automatic logic [31:0] mix_tail_bytes(input logic [31:0] acc,
                                                 input logic [31:0] w,
                                                 input logic [2:0]  nb);
    logic [31:0] mask;
    case (nb)
      3'd1: mask = 32'h0000_00ff;
      3'd2: mask = 32'h0000_ffff;
      default: mask = 32'h00ff_ffff;
    endcase
    return (acc ^ (w & mask)) * MIX_MUL;
  endfunction

  // Final avalanche applied before the hash leaves the block
  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> FIN_SHIFT_A);
    x = x * MIX_MUL;
    x = x ^ (x >> FIN_SHIFT_B);
    return x;
  endfunction

  always @(posedge clk) begin : monitor
    logic [31:0] h;
    logic [2:0]  nb;
    logic [31:0] want;
    if (!rst_n) begin
      seed_reg = '0;
      running_hash = '0;
      hash_expect_q.delete();
    end else begin
      // Compare a delivered hash with the oldest prediction
      if (out_valid && !out_stall) begin
        if (hash_expect_q.size() == 0) begin
          $display("%0t: unexpected hash: expected none, actual %h", $time, out_hash_value);
          n_fail++;
        end else begin
          want = hash_expect_q.pop_front();
          if (out_hash_value !== want) begin
            $display("%0t: hash mismatch: expected %h, actual %h", $time, want,
                     out_hash_value);
            n_fail++;
          end
        end
      end
      // Advance the running hash on each accepted word
      if (in_valid && !in_stall) begin
        h = running_hash;
        nb = (in_valid_bytes > FULL_WORD_BYTES) ? 3'(FULL_WORD_BYTES) : in_valid_bytes;
        if (in_first_item)
          h = seed_reg ^ {1'b0, in_key_length};
        if (nb == FULL_WORD_BYTES)
          h = mix_full_word(h, in_data_word);
        else if (nb != 0)
          h = mix_tail_bytes(h, in_data_word, nb);
        running_hash = h;
        if (in_last_item)
          hash_expect_q.push_back(avalanche(h));
      end
      if (cfg_we)
        seed_reg = cfg_wdata;
    end
    n_pending = hash_expect_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the murmur2_hash32 testbench: clock, reset, key word stimulus,
// seed writes, receiver stalls and the verdict. Uses mh2_checker.
module tb;

  localparam int IDLE_LIMIT     = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_COUNT    = 6;
  localparam int WORDS_PER_PHASE = 175;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic        in_first_item = 1'b0;
  logic        in_last_item = 1'b0;
  logic [30:0] in_key_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;

  int n_fail;
  int n_pending;
  int idle_cycles = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  murmur2_hash32 u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_valid_bytes(in_valid_bytes),
    .in_first_item (in_first_item),
    .in_last_item  (in_last_item),
    .in_key_length (in_key_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value)
  );

  mh2_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_valid_bytes(in_valid_bytes),
    .in_first_item (in_first_item),
    .in_last_item  (in_last_item),
    .in_key_length (in_key_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value),
    .n_fail        (n_fail),
    .n_pending     (n_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // End the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("murmur2_hash32 verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic first,
                           input logic last, input logic [30:0] klen);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_word   <= data;
    in_valid_bytes <= nb;
    in_first_item  <= first;
    in_last_item   <= last;
    in_key_length  <= klen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Stream a key of nbytes bytes; the length field rides on the first word
  task automatic send_key(input int nbytes, input logic [30:0] klen, input bit with_first);
    int nwords;
    int tail;
    nwords = nbytes / 4;
    tail = nbytes % 4;
    if (nbytes == 0) begin
      send_word($urandom, 3'd0, with_first, 1'b1, klen);
    end else begin
      for (int i = 0; i < nwords; i++) begin
        send_word($urandom, 3'd4, with_first && i == 0, tail == 0 && i == nwords - 1,
                  (i == 0) ? klen : 31'($urandom));
      end
      if (tail != 0)
        send_word($urandom, 3'(tail), with_first && nwords == 0, 1'b1,
                  (nwords == 0) ? klen : 31'($urandom));
    end
  endtask

  // Drop valid, let every hash come out, then let the pipeline settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] phase_seed;
    int          r;
    int          nbytes;
    logic [30:0] klen;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no first word after reset folds into a zero accumulator
    send_word(32'h1234_5678, 3'd4, 1'b0, 1'b1, 31'd0);
    drain();
    write_seed(32'h0);
    // Empty keys, with zero and maximum length fields
    send_word(32'h0, 3'd0, 1'b1, 1'b1, 31'd0);
    send_word(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 31'h7fff_ffff);
    // One, two and three byte keys with stray bits above the tail, then a four byte key
    send_word(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 31'd1);
    send_word(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 31'd2);
    send_word(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 31'd3);
    send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 31'd4);
    // Byte counts above four count as a full word
    send_word(32'ha5a5_5a5a, 3'd5, 1'b1, 1'b1, 31'd4);
    send_word(32'h0000_0000, 3'd6, 1'b1, 1'b1, 31'd4);
    send_word(32'h8000_0001, 3'd7, 1'b1, 1'b1, 31'h4000_0000);
    // Empty word in the middle of a key
    send_word(32'hdead_beef, 3'd4, 1'b1, 1'b0, 31'd8);
    send_word(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 31'h7fff_ffff);
    send_word(32'h0bad_f00d, 3'd4, 1'b0, 1'b1, 31'd0);
    // Partial word that is not last
    send_word(32'hcafe_babe, 3'd2, 1'b1, 1'b0, 31'd6);
    send_word(32'h1357_9bdf, 3'd4, 1'b0, 1'b1, 31'd0);
    // Continue after a hash without a new first word
    send_word(32'h2468_ace0, 3'd4, 1'b0, 1'b1, 31'd0);
    send_key(8, 31'd8, 1'b1);
    send_key(5, 31'd5, 1'b1);
    drain();

    // Random phases, each writing its own seed and using one of four idling patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: phase_seed = 32'hffff_ffff;
        2: phase_seed = 32'h0000_0000;
        4: phase_seed = 32'h8000_0000;
        default: phase_seed = $urandom;
      endcase
      write_seed(phase_seed);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct = 9;
          recv_stall_pct = 9;
        end
      endcase
      // Fill the block behind a long receiver hold-off
      if (p == 2)
        hold_req = 1'b1;
      words_sent = 0;
      while (words_sent < WORDS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(0, 16);
        klen = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'(nbytes);
        if (r < 82)
          send_key(nbytes, klen, 1'b1);
        else if (r < 88)
          send_key(nbytes, klen, 1'b0);
        else
          send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 31'($urandom));
      end
      drain();
    end

    if (n_fail == 0 && n_pending == 0) begin
      $display("murmur2_hash32 verification clean");
    end else begin
      $display("murmur2_hash32 verification failed");
    end
    $finish;
  end

endmodule

@@ murmur2_hash32.f @@
design/mh2_pkg.sv
design/mh2_front.sv
design/mh2_queue.sv
design/mh2_back.sv
design/murmur2_hash32.sv
tb/sv/mh2_checker.sv
tb/sv/tb.sv
